// File: src/assert_macros.svh
// Assertion macros for the RTL; rgbov_ctrl is the only file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: src/rgbov_pkg.sv
package rgbov_pkg;

    localparam int NUM_LANES  = 4;
    localparam int NUM_STAGES = 4;
    localparam int PIX_W      = 32;
    localparam int SAMPLE_W   = 8;
    localparam int DATA_IN_W  = NUM_LANES * PIX_W + (NUM_LANES + 2) * SAMPLE_W;
    localparam int DATA_OUT_W = (NUM_LANES + 2) * SAMPLE_W;

    localparam logic [15:0] COEF_YR = 16'd66;
    localparam logic [15:0] COEF_YG = 16'd129;
    localparam logic [15:0] COEF_YB = 16'd25;
    localparam logic [15:0] COEF_UR = 16'd112;
    localparam logic [15:0] COEF_UG = 16'd94;
    localparam logic [15:0] COEF_UB = 16'd18;
    localparam logic [15:0] COEF_VR = 16'd38;
    localparam logic [15:0] COEF_VG = 16'd74;
    localparam logic [15:0] COEF_VB = 16'd112;
    localparam logic [7:0]  LUMA_BIAS = 8'd16;
    localparam logic [15:0] UV_BIAS  = 16'd32768;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

    // Numerator of the blend: d*(255-a) + s*a, written as 255*d + a*(s-d).
    function automatic logic [15:0] mix_sum(input logic [7:0] d, input logic [7:0] s,
                                            input logic [7:0] a);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic [17:0]        tot;
        diff = $signed({1'b0, s}) - $signed({1'b0, d});
        prod = diff * $signed({1'b0, a});
        tot  = {2'b00, d, 8'h00} - {10'd0, d} + $unsigned(prod);
        return tot[15:0];
    endfunction

    // Exact floor(x / 255) for every numerator the blend can produce.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

// File: src/rgba_overlay_yuv420_blend.sv
// Channel | Direction | Contents
// s_      | in        | one 2x2 RGBA block, four luma samples, Cb, Cr; inside flag
// m_      | out       | four blended luma samples, blended Cb and Cr
//
// Each block passes through every pipeline stage in turn; one block per cycle while s_tready is high.
// The four pixel lanes and the chroma merge share one four-stage pipeline.
// Reset clears only the stage valid flags; data registers are not reset.
// A stalled output fills empty stages first, then holds s_tready low.
module rgba_overlay_yuv420_blend
    import rgbov_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // cb_in, cr_in
    input  logic [DATA_IN_W-1:0]  s_tdata,
    // inside_req
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // luma_out_top_left, luma_out_top_right, luma_out_bottom_left,
    // luma_out_bottom_right, cb_out, cr_out
    output logic [DATA_OUT_W-1:0] m_tdata
);

    localparam int LUMA_BASE = NUM_LANES * PIX_W;
    localparam int CB_BASE   = LUMA_BASE + NUM_LANES * SAMPLE_W;
    localparam int CR_BASE   = CB_BASE + SAMPLE_W;

    stage_ctl_t                ctl;
    logic [NUM_LANES-1:0][7:0] lane_u;
    logic [NUM_LANES-1:0][7:0] lane_v;
    logic [NUM_LANES-1:0][7:0] lane_alpha;
    logic [NUM_LANES-1:0][7:0] lane_luma;
    logic [7:0]                cb_out;
    logic [7:0]                cr_out;

    rgbov_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        rgbov_lane u_lane (
            .aclk         (aclk),
            .ctl          (ctl),
            .pixel        (s_tdata[i*PIX_W +: PIX_W]),
            .luma         (s_tdata[LUMA_BASE + i*SAMPLE_W +: SAMPLE_W]),
            .in_frame     (s_tuser),
            .u_reg        (lane_u[i]),
            .v_reg        (lane_v[i]),
            .alpha_reg    (lane_alpha[i]),
            .luma_out_reg (lane_luma[i])
        );
    end

    rgbov_merge u_merge (
        .aclk       (aclk),
        .ctl        (ctl),
        .lane_u     (lane_u),
        .lane_v     (lane_v),
        .lane_alpha (lane_alpha),
        .cb_in      (s_tdata[CB_BASE +: SAMPLE_W]),
        .cr_in      (s_tdata[CR_BASE +: SAMPLE_W]),
        .in_frame   (s_tuser),
        .cb_out_reg (cb_out),
        .cr_out_reg (cr_out)
    );

    assign m_tdata = {cr_out, cb_out, lane_luma};

endmodule

// File: src/rgbov_ctrl.sv
`include "assert_macros.svh"

module rgbov_ctrl
    import rgbov_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output stage_ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    always_comb begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb begin
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load = ready;
    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    `ASSERT_AT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready |=> valid_reg[0])
    `ASSERT_AT(a_blocked_holds, aclk, aresetn, valid_reg[2] && !ready[2] |=> valid_reg[2])
    `ASSERT_NEVER(a_full_no_accept, aclk, aresetn, (&valid_reg) && !m_tready && s_tready)

endmodule

// File: src/rgbov_lane.sv
module rgbov_lane
    import rgbov_pkg::*;
(
    input  logic             aclk,
    input  stage_ctl_t       ctl,
    input  logic [PIX_W-1:0] pixel,
    input  logic [7:0]       luma,
    input  logic             in_frame,
    output logic [7:0]       u_reg,
    output logic [7:0]       v_reg,
    output logic [7:0]       alpha_reg,
    output logic [7:0]       luma_out_reg
);

    logic [15:0] r16;
    logic [15:0] g16;
    logic [15:0] b16;
    logic [15:0] y_sum;
    logic [15:0] u_sum;
    logic [15:0] v_sum;

    logic [7:0]  y_reg;
    logic [7:0]  d1_reg;
    logic        inside1_reg;
    logic [15:0] num_reg;
    logic [7:0]  quot_reg;

    assign r16 = {8'd0, pixel[31:24]};
    assign g16 = {8'd0, pixel[23:16]};
    assign b16 = {8'd0, pixel[15:8]};

    assign y_sum = COEF_YR * r16 + COEF_YG * g16 + COEF_YB * b16;
    assign u_sum = COEF_UR * r16 + UV_BIAS - COEF_UG * g16 - COEF_UB * b16;
    assign v_sum = COEF_VB * b16 + UV_BIAS - COEF_VR * r16 - COEF_VG * g16;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            y_reg       <= y_sum[15:8] + LUMA_BIAS;
            u_reg       <= u_sum[15:8];
            v_reg       <= v_sum[15:8];
            alpha_reg   <= pixel[7:0];
            d1_reg      <= luma;
            inside1_reg <= in_frame;
        end
        if (ctl.load[1]) begin
            num_reg <= mix_sum(d1_reg, y_reg, inside1_reg ? alpha_reg : 8'd0);
        end
        if (ctl.load[2]) begin
            quot_reg <= div255(num_reg);
        end
        if (ctl.load[3]) begin
            luma_out_reg <= quot_reg;
        end
    end

endmodule

// File: src/rgbov_merge.sv
module rgbov_merge
    import rgbov_pkg::*;
(
    input  logic                       aclk,
    input  stage_ctl_t                 ctl,
    input  logic [NUM_LANES-1:0][7:0]  lane_u,
    input  logic [NUM_LANES-1:0][7:0]  lane_v,
    input  logic [NUM_LANES-1:0][7:0]  lane_alpha,
    input  logic [7:0]                 cb_in,
    input  logic [7:0]                 cr_in,
    input  logic                       in_frame,
    output logic [7:0]                 cb_out_reg,
    output logic [7:0]                 cr_out_reg
);

    logic [9:0]  sum_u;
    logic [9:0]  sum_v;
    logic [9:0]  sum_a;

    logic [7:0]  cb1_reg;
    logic [7:0]  cr1_reg;
    logic        inside1_reg;
    logic [7:0]  cb2_reg;
    logic [7:0]  cr2_reg;
    logic [7:0]  avg_u_reg;
    logic [7:0]  avg_v_reg;
    logic [7:0]  avg_a_reg;
    logic [15:0] num_u_reg;
    logic [15:0] num_v_reg;

    always_comb begin
        sum_u = '0;
        sum_v = '0;
        sum_a = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            sum_u = sum_u + {2'b00, lane_u[i]};
            sum_v = sum_v + {2'b00, lane_v[i]};
            sum_a = sum_a + {2'b00, lane_alpha[i]};
        end
    end

    // A zero average alpha makes the blend return the frame sample, which
    // also covers blocks outside the frame.
    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            cb1_reg     <= cb_in;
            cr1_reg     <= cr_in;
            inside1_reg <= in_frame;
        end
        if (ctl.load[1]) begin
            cb2_reg   <= cb1_reg;
            cr2_reg   <= cr1_reg;
            avg_u_reg <= sum_u[9:2];
            avg_v_reg <= sum_v[9:2];
            avg_a_reg <= inside1_reg ? sum_a[9:2] : 8'd0;
        end
        if (ctl.load[2]) begin
            num_u_reg <= mix_sum(cb2_reg, avg_u_reg, avg_a_reg);
            num_v_reg <= mix_sum(cr2_reg, avg_v_reg, avg_a_reg);
        end
        if (ctl.load[3]) begin
            cb_out_reg <= div255(num_u_reg);
            cr_out_reg <= div255(num_v_reg);
        end
    end

endmodule

// File: test/rgba_overlay_yuv420_blend_tb.sv
module rgba_overlay_yuv420_blend_tb
    import rgbov_pkg::*;
();

    typedef struct packed {
        logic                 in_frame;
        logic [DATA_IN_W-1:0] data;
    } overlay_block_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;

    overlay_block_t        pending_blocks[$];
    logic [DATA_OUT_W-1:0] expected_samples[$];
    overlay_block_t        next_block;
    logic [DATA_OUT_W-1:0] want_samples;
    logic                  block_taken = 1'b0;
    int                    sender_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    mismatch_count = 0;
    string                 field_name[6] = '{"luma_out_top_left", "luma_out_top_right",
                                             "luma_out_bottom_left", "luma_out_bottom_right",
                                             "cb_out", "cr_out"};

    rgba_overlay_yuv420_blend DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [7:0] weighted_mix(input int unsigned d, input int unsigned s,
                                                input int unsigned a);
        int unsigned num;
        num = d * (255 - a) + s * a;
        return 8'((num / 255) & 32'hff);
    endfunction

    function automatic logic [DATA_OUT_W-1:0] overlay_result(input logic [DATA_IN_W-1:0] data,
                                                             input logic in_frame);
        int unsigned r, g, b, a, y, sum_u, sum_v, sum_a;
        logic [DATA_OUT_W-1:0] res;
        res = data[DATA_IN_W-1 -: DATA_OUT_W];
        if (!in_frame) begin
            return res;
        end
        sum_u = 0;
        sum_v = 0;
        sum_a = 0;
        for (int k = 0; k < 4; k++) begin
            r = data[32*k+24 +: 8];
            g = data[32*k+16 +: 8];
            b = data[32*k+8 +: 8];
            a = data[32*k +: 8];
            y = ((66 * r + 129 * g + 25 * b) >> 8) + 16;
            sum_u += (112 * r + 32768 - 94 * g - 18 * b) >> 8;
            sum_v += (112 * b + 32768 - 38 * r - 74 * g) >> 8;
            sum_a += a;
            if (a == 255) begin
                res[8*k +: 8] = 8'(y);
            end else if (a != 0) begin
                res[8*k +: 8] = weighted_mix(res[8*k +: 8], y, a);
            end
        end
        if (sum_a != 0) begin
            res[32 +: 8] = weighted_mix(res[32 +: 8], sum_u >> 2, sum_a >> 2);
            res[40 +: 8] = weighted_mix(res[40 +: 8], sum_v >> 2, sum_a >> 2);
        end
        return res;
    endfunction

    // Lumas are packed as {bottom_right, bottom_left, top_right, top_left}.
    task automatic add_block(input logic [31:0] tl, input logic [31:0] tr,
                             input logic [31:0] bl, input logic [31:0] br,
                             input logic [31:0] lumas, input logic [7:0] cb,
                             input logic [7:0] cr, input logic in_frame);
        overlay_block_t blk;
        blk.in_frame = in_frame;
        blk.data     = {cr, cb, lumas, br, bl, tr, tl};
        pending_blocks.push_back(blk);
    endtask

    function automatic logic [7:0] pick_alpha();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 2) begin
            return 8'd0;
        end else if (sel < 4) begin
            return 8'd255;
        end else if (sel == 4) begin
            return 8'($urandom_range(3, 1));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic add_random_blocks(input int count);
        logic [31:0] px[4];
        int unsigned mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(19);
            for (int k = 0; k < 4; k++) begin
                px[k][31:8] = 24'($urandom);
                if (mode == 0) begin
                    px[k][7:0] = 8'd0;
                end else if (mode == 1) begin
                    px[k][7:0] = 8'($urandom_range(1));
                end else begin
                    px[k][7:0] = pick_alpha();
                end
            end
            add_block(px[0], px[1], px[2], px[3], $urandom, 8'($urandom), 8'($urandom),
                      $urandom_range(99) < 85);
        end
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() != 0 || s_tvalid || expected_samples.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || block_taken) begin
            if (pending_blocks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_block = pending_blocks.pop_front();
                s_tdata  <= next_block.data;
                s_tuser  <= next_block.in_frame;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    always @(posedge aclk) begin
        block_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_samples.push_back(overlay_result(s_tdata, s_tuser));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result transfer: %h", m_tdata);
                end
            end else begin
                want_samples = expected_samples.pop_front();
                for (int f = 0; f < 6; f++) begin
                    if (m_tdata[8*f +: 8] !== want_samples[8*f +: 8]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch on %s: expected %h, got %h", field_name[f],
                                     want_samples[8*f +: 8], m_tdata[8*f +: 8]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_block(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'h12345678, 8'h9A, 8'hBC, 1'b0);
        add_block(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00, 1'b0);
        add_block(32'hFFFFFF00, 32'h00000000, 32'h80FF4000, 32'h12345600,
                  32'hFF0080_01, 8'h00, 8'hFF, 1'b1);
        add_block(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'h0, 8'h00, 8'h00, 1'b1);
        add_block(32'h000000FF, 32'h000000FF, 32'h000000FF, 32'h000000FF,
                  32'hFFFFFFFF, 8'hFF, 8'hFF, 1'b1);
        add_block(32'hFF0000FF, 32'h00FF00FF, 32'h0000FFFF, 32'hFFFFFFFF,
                  32'h80808080, 8'h80, 8'h80, 1'b1);
        add_block(32'hFF000001, 32'h00FF0000, 32'h0000FF00, 32'hFFFFFF00,
                  32'h10F0_20E0, 8'h40, 8'hC0, 1'b1);
        add_block(32'hFF000001, 32'h00FF0001, 32'h0000FF01, 32'hFFFFFF00,
                  32'hA0B0C0D0, 8'hFF, 8'h00, 1'b1);
        add_block(32'hFF000001, 32'h00FF0001, 32'h0000FF01, 32'h00000001,
                  32'hA0B0C0D0, 8'hFF, 8'h00, 1'b1);
        add_block(32'hFF00FFFE, 32'h00FFFF01, 32'hFFFF0080, 32'h0000007F,
                  32'hFF00FF00, 8'h00, 8'hFF, 1'b1);
        add_block(32'hFFFFFF80, 32'h00000080, 32'hFF000080, 32'h0000FF80,
                  32'hFFFFFFFF, 8'h00, 8'hFF, 1'b1);
        add_block(32'h12345600, 32'hFEDCBAFF, 32'h55AA5500, 32'hAA55AAFF,
                  32'h00FF00FF, 8'h55, 8'hAA, 1'b1);
        add_block(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00, 1'b1);
        add_block(32'h000000FE, 32'h000000FE, 32'h000000FE, 32'h000000FE,
                  32'hFFFFFFFF, 8'hFF, 8'hFF, 1'b1);
        add_random_blocks(8);
        wait_drained();

        for (int rep = 0; rep < 2; rep++) begin
            for (int ph = 0; ph < 4; ph++) begin
                sender_idle_pct = (ph == 1) ? 54 : (ph == 3) ? 21 : 0;
                recv_stall_pct  = (ph == 2) ? 54 : (ph == 3) ? 21 : 0;
                add_random_blocks(150);
                wait_drained();
            end
        end

        repeat (20) @(posedge aclk);
        if (expected_samples.size() != 0) begin
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/rgbov_pkg.sv
src/rgbov_ctrl.sv
src/rgbov_lane.sv
src/rgbov_merge.sv
src/rgba_overlay_yuv420_blend.sv
test/rgba_overlay_yuv420_blend_tb.sv
